// ===== hdl/hpti_pkg.sv =====
// Shared types and constants for the hashed page table insert block.
package hpti_pkg;

  localparam int HASH_W     = 19;
  localparam int SLOT_W     = 3;
  localparam int SLOTS      = 8;
  localparam int WORD_W     = 32;
  localparam int ROW_W      = SLOTS * WORD_W;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 120;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ORIGIN = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_MASK   = 8'd1;

  typedef enum logic [1:0] {
    OUT_MATCH = 2'd0,
    OUT_FREE  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic [HASH_W-1:0] group;
    logic [WORD_W-1:0] entry_high;
    logic [WORD_W-1:0] entry_low;
    logic [WORD_W-1:0] entry_address;
  } item_t;

endpackage

// ===== hdl/hashed_page_table_insert_top.sv =====
// Top level of the hashed page table insert block.
//
//   channel  dir  handshake              payload
//   in_      in   in_tvalid/in_tready    in_tdata: 88 bits
//   out_     out  out_tvalid/out_tready  out_tdata: 120 bits
//   cfg_     in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// Each item passes through the insert engine in turn: group row read, compare
// of the eight slots, write back with result load.
// After reset the engine clears all 2**GROUP_INDEX_BITS group rows of the
// table, one group row per cycle; input items queue up meanwhile, config is taken.
// A two-entry queue decouples input accept from the engine; a stalled
// output holds the engine in its write step.
module hashed_page_table_insert_top #(
  parameter int GROUP_INDEX_BITS = 10
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hpti_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hpti_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // virtual_address[31:0], segment_id[55:32], real_page[75:56], page_mode[87:76]
  input  logic [hpti_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // group_index[18:0], slot[21:19], outcome[23:22], entry_high[55:24],
  // entry_low[87:56], entry_address[119:88]
  output logic [hpti_pkg::OUT_DATA_W-1:0]  out_tdata
);

  logic            push;
  hpti_pkg::item_t push_item;
  logic            q_full;
  logic            pop;
  logic            q_valid;
  hpti_pkg::item_t q_item;

  hpti_front #(
    .GROUP_INDEX_BITS (GROUP_INDEX_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  hpti_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  hpti_back #(
    .GROUP_INDEX_BITS (GROUP_INDEX_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== hdl/hpti_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
module hpti_ram #(
  parameter int WIDTH = 256,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/hpti_front.sv =====
// Front end: config registers, input accept, hash and entry word formation.
module hpti_front #(
  parameter int GROUP_INDEX_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hpti_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hpti_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [hpti_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            push,
  output hpti_pkg::item_t                 push_item,
  input  logic                            q_full
);

  localparam logic [hpti_pkg::HASH_W-1:0] StoreMask =
    hpti_pkg::HASH_W'((32'd1 << GROUP_INDEX_BITS) - 32'd1);

  logic [15:0] table_origin_r;
  logic [8:0]  table_mask_r;

  logic [31:0] va;
  logic [23:0] vsid;
  logic [19:0] rpn;
  logic [11:0] mode;
  logic [hpti_pkg::HASH_W-1:0] hash;
  logic [hpti_pkg::HASH_W-1:0] hmask;
  logic [hpti_pkg::HASH_W-1:0] group;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_origin_r <= '0;
      table_mask_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        hpti_pkg::CFG_TABLE_ORIGIN: table_origin_r <= cfg_data;
        hpti_pkg::CFG_TABLE_MASK:   table_mask_r   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  assign va   = in_tdata[31:0];
  assign vsid = in_tdata[55:32];
  assign rpn  = in_tdata[75:56];
  assign mode = in_tdata[87:76];

  assign hash  = vsid[18:0] ^ {3'b000, va[27:12]};
  assign hmask = {table_mask_r, 10'h3ff} & StoreMask;
  assign group = hash & hmask;

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  assign push_item.group         = group;
  assign push_item.entry_high    = {1'b1, vsid, 1'b0, va[27:22]};
  assign push_item.entry_low     = {rpn, mode};
  assign push_item.entry_address = {table_origin_r, 16'h0000} + {7'd0, group, 6'd0};

endmodule

// ===== hdl/hpti_queue.sv =====
// Short FIFO between the front end and the insert engine.
module hpti_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  hpti_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output hpti_pkg::item_t q_item
);

  hpti_pkg::item_t entries [hpti_pkg::QUEUE_DEPTH];
  logic [hpti_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [hpti_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [hpti_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic do_pop;

  assign full    = (count_r == hpti_pkg::QCNT_W'(hpti_pkg::QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = entries[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hdl/hpti_back.sv =====
// Insert engine: clear pass, group read, slot choice, write back, result register.
module hpti_back #(
  parameter int GROUP_INDEX_BITS = 10
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  input  hpti_pkg::item_t                  q_item,
  output logic                             pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [hpti_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int Rows = 1 << GROUP_INDEX_BITS;

  hpti_pkg::state_t state_r, state_nxt;
  hpti_pkg::item_t  item_r;
  logic [GROUP_INDEX_BITS-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [hpti_pkg::SLOT_W-1:0] victim_r, victim_nxt;
  logic [hpti_pkg::SLOT_W-1:0] slot_r;
  hpti_pkg::outcome_t          outcome_r;
  logic [hpti_pkg::ROW_W-1:0]  row_r;
  logic                        out_valid_r, out_valid_nxt;
  logic [hpti_pkg::OUT_DATA_W-1:0] out_data_r;

  logic                        rd_en;
  logic [GROUP_INDEX_BITS-1:0] rd_addr;
  logic [hpti_pkg::ROW_W-1:0]  rd_data;
  logic                        wr_en;
  logic [GROUP_INDEX_BITS-1:0] wr_addr;
  logic [hpti_pkg::ROW_W-1:0]  wr_data;
  logic                        out_free;
  logic                        load_out;
  logic                        eval_en;

  logic [hpti_pkg::SLOTS-1:0]  hit_vec, free_vec;
  logic [hpti_pkg::SLOT_W-1:0] hit_slot, free_slot, pick_slot;
  hpti_pkg::outcome_t          pick_outcome;
  logic [hpti_pkg::ROW_W-1:0]  new_row;

  hpti_ram #(
    .WIDTH (hpti_pkg::ROW_W),
    .DEPTH (Rows)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free = !out_valid_r || out_tready;

  // slot choice: first match, else first free, else round-robin victim
  always_comb begin
    hit_slot  = '0;
    free_slot = '0;
    for (int k = 0; k < hpti_pkg::SLOTS; k++) begin
      hit_vec[k]  = (rd_data[k*hpti_pkg::WORD_W +: hpti_pkg::WORD_W] == item_r.entry_high);
      free_vec[k] = !rd_data[k*hpti_pkg::WORD_W + hpti_pkg::WORD_W - 1];
    end
    for (int k = hpti_pkg::SLOTS - 1; k >= 0; k--) begin
      if (hit_vec[k]) begin
        hit_slot = hpti_pkg::SLOT_W'(k);
      end
      if (free_vec[k]) begin
        free_slot = hpti_pkg::SLOT_W'(k);
      end
    end
    if (hit_vec != '0) begin
      pick_slot    = hit_slot;
      pick_outcome = hpti_pkg::OUT_MATCH;
    end else if (free_vec != '0) begin
      pick_slot    = free_slot;
      pick_outcome = hpti_pkg::OUT_FREE;
    end else begin
      pick_slot    = victim_r;
      pick_outcome = hpti_pkg::OUT_EVICT;
    end
  end

  always_comb begin
    for (int k = 0; k < hpti_pkg::SLOTS; k++) begin
      if (slot_r == hpti_pkg::SLOT_W'(k)) begin
        new_row[k*hpti_pkg::WORD_W +: hpti_pkg::WORD_W] = item_r.entry_high;
      end else begin
        new_row[k*hpti_pkg::WORD_W +: hpti_pkg::WORD_W] =
          row_r[k*hpti_pkg::WORD_W +: hpti_pkg::WORD_W];
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hpti_pkg::ST_CLEAR: begin
        if (clr_cnt_r == '1) begin
          state_nxt = hpti_pkg::ST_IDLE;
        end
      end
      hpti_pkg::ST_IDLE: begin
        if (q_valid) begin
          state_nxt = hpti_pkg::ST_EVAL;
        end
      end
      hpti_pkg::ST_EVAL: state_nxt = hpti_pkg::ST_WRITE;
      hpti_pkg::ST_WRITE: begin
        if (out_free) begin
          state_nxt = hpti_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hpti_pkg::ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    pop         = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = q_item.group[GROUP_INDEX_BITS-1:0];
    wr_en       = 1'b0;
    wr_addr     = item_r.group[GROUP_INDEX_BITS-1:0];
    wr_data     = new_row;
    load_out    = 1'b0;
    eval_en     = 1'b0;
    clr_cnt_nxt = clr_cnt_r;
    victim_nxt  = victim_r;
    case (state_r)
      hpti_pkg::ST_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        wr_data     = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      hpti_pkg::ST_IDLE: begin
        pop   = q_valid;
        rd_en = q_valid;
      end
      hpti_pkg::ST_EVAL: begin
        eval_en = 1'b1;
      end
      hpti_pkg::ST_WRITE: begin
        if (out_free) begin
          wr_en    = 1'b1;
          load_out = 1'b1;
          if (outcome_r == hpti_pkg::OUT_EVICT) begin
            victim_nxt = victim_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hpti_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      victim_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      victim_r    <= victim_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= q_item;
    end
    if (eval_en) begin
      slot_r    <= pick_slot;
      outcome_r <= pick_outcome;
      row_r     <= rd_data;
    end
    if (load_out) begin
      out_data_r <= {item_r.entry_address, item_r.entry_low, item_r.entry_high,
                     outcome_r, slot_r, item_r.group};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
